[rtl/hrb_pkg.sv]
// shared types, codes and constants for the halo region bounds block
`default_nettype none

package hrb_pkg;

    // region kind codes
    typedef logic [3:0] func_t;

    localparam func_t FN_SEND_SAME    = 4'd0;
    localparam func_t FN_SEND_SAMEC   = 4'd1;
    localparam func_t FN_SEND_COARSER = 4'd2;
    localparam func_t FN_SEND_FINER   = 4'd3;
    localparam func_t FN_SEND_FLUX    = 4'd4;
    localparam func_t FN_RECV_SAME    = 4'd5;
    localparam func_t FN_RECV_SAMEC   = 4'd6;
    localparam func_t FN_RECV_COARSER = 4'd7;
    localparam func_t FN_RECV_FINER   = 4'd8;
    localparam func_t FN_RECV_PROLONG = 4'd9;
    localparam func_t FN_RECV_FLUX    = 4'd10;

    // configuration register indexes
    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_GHOST_WIDTH = 2'd0;
    localparam reg_idx_t REG_CELLS_X1    = 2'd1;
    localparam reg_idx_t REG_CELLS_X2    = 2'd2;
    localparam reg_idx_t REG_CELLS_X3    = 2'd3;

    localparam int CFG_DATA_W = 9;
    localparam int GHOST_W    = 4;
    localparam int CELLS_W    = 9;

    localparam logic [GHOST_W-1:0] GHOST_RESET = 4'd2;
    localparam logic [CELLS_W-1:0] CELLS_RESET = 9'd16;

    // default limits handed to the top level
    localparam int DEF_MAX_CELLS = 256;
    localparam int DEF_MAX_GHOST = 8;

    // result fields
    localparam int COORD_W = 11;
    localparam int COUNT_W = 25;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h1FF_FFFF;

    // stream widths
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 96;
    localparam int M_USER_W = 1;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // per-item classification carried alongside the boxes
    typedef struct packed {
        logic valid_res;
        logic add_same;
    } hrb_flags_t;

endpackage

`default_nettype wire

[rtl/hrb_axis.sv]
// index range on one axis for one region kind
`default_nettype none

module hrb_axis #(
    parameter int CW = 9,
    parameter int GW = 4,
    parameter int IW = 12
) (
    input  hrb_pkg::func_t  func,
    input  logic [1:0]      dir,
    input  logic            sel,
    input  logic            split_ok,
    input  logic [GW-1:0]   ghost,
    input  logic [CW-1:0]   cells,
    output logic [IW-1:0]   lo,
    output logic [IW-1:0]   hi
);
    import hrb_pkg::*;

    logic          collapsed;
    logic          pos;
    logic          neg;
    logic          split;
    logic [IW-1:0] g;
    logic [IW-1:0] n;
    logic [IW-1:0] cn;
    logic [IW-1:0] w;
    logic [IW-1:0] a;
    logic [IW-1:0] e;
    logic [IW-1:0] ce;
    logic [IW-1:0] b;
    logic [IW-1:0] one;

    // interior and coarse interior of this axis
    assign one       = IW'(1);
    assign g         = IW'(ghost);
    assign n         = IW'(cells);
    assign cn        = IW'(cells >> 1);
    assign collapsed = (cells <= CW'(1));
    assign a         = collapsed ? '0 : g;
    assign e         = collapsed ? '0 : g + n - one;
    assign ce        = collapsed ? '0 : g + cn - one;
    assign w         = (func == FN_RECV_PROLONG) ? (g >> 1) : g;

    // direction decode, the pattern 2'b10 counts as negative
    assign pos   = (dir == 2'b01);
    assign neg   = dir[1];
    assign split = (dir == 2'b00) && split_ok;

    // far end of the box depends on whether the kind works on the coarse interior
    always_comb
    begin
        unique case (func) inside
            FN_SEND_SAMEC, FN_SEND_COARSER, FN_SEND_FLUX,
            FN_RECV_SAMEC, FN_RECV_COARSER, FN_RECV_PROLONG:
                b = ce;
            default:
                b = e;
        endcase
    end

    // box ends per kind family, then the sub-block adjustment
    always_comb
    begin
        if (func <= FN_SEND_FINER)
        begin
            lo = pos ? b - g + one : a;
            hi = neg ? a + g - one : b;
            if (func == FN_SEND_FINER && split)
            begin
                if (sel)
                    lo = lo + cn - g;
                else
                    hi = hi - cn + g;
            end
        end
        else if (func == FN_SEND_FLUX || func == FN_RECV_FLUX)
        begin
            lo = pos ? b + one : a;
            hi = pos ? b + one : (neg ? a : b);
            if (func == FN_RECV_FLUX && split)
            begin
                if (sel)
                    lo = lo + cn;
                else
                    hi = hi - cn;
            end
        end
        else
        begin
            lo = pos ? b + one : (neg ? a - w : a);
            hi = pos ? b + w : (neg ? a - one : b);
            if (split && (func == FN_RECV_COARSER || func == FN_RECV_PROLONG))
            begin
                if (sel)
                    lo = lo - w;
                else
                    hi = hi + w;
            end
            if (split && func == FN_RECV_FINER)
            begin
                if (sel)
                    lo = lo + cn;
                else
                    hi = hi - cn;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/hrb_front.sv]
// front end: takes requests, classifies them and works out the boxes
`default_nettype none

module hrb_front #(
    parameter int MAX_CELLS = 256,
    parameter int MAX_GHOST = 8,
    parameter int IW        = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  hrb_pkg::func_t               func,
    input  logic [1:0]                   dir_x1,
    input  logic [1:0]                   dir_x2,
    input  logic [1:0]                   dir_x3,
    input  logic                         sub_a,
    input  logic                         sub_b,
    input  logic [hrb_pkg::GHOST_W-1:0]  ghost_width,
    input  logic [hrb_pkg::CELLS_W-1:0]  cells_x1,
    input  logic [hrb_pkg::CELLS_W-1:0]  cells_x2,
    input  logic [hrb_pkg::CELLS_W-1:0]  cells_x3,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0][IW-1:0]           main_lo,
    output logic [2:0][IW-1:0]           main_hi,
    output logic [2:0][IW-1:0]           alt_lo,
    output logic [2:0][IW-1:0]           alt_hi,
    output hrb_pkg::hrb_flags_t          flags
);
    import hrb_pkg::*;

    localparam int CW  = $clog2(MAX_CELLS + 1);
    localparam int GW  = $clog2(MAX_GHOST + 1);
    localparam int CCW = (CW > CELLS_W) ? CW : CELLS_W;
    localparam int GCW = (GW > GHOST_W) ? GW : GHOST_W;

    logic [2:0][CELLS_W-1:0] cells_in;
    logic [2:0][CW-1:0]      cells;
    logic [GW-1:0]           ghost;
    logic [2:0][1:0]         dir;
    logic [2:0]              sel;
    logic [2:0]              split_ok;
    func_t                   alt_func;
    logic                    same_kind;
    hrb_flags_t              flags_next;
    logic [2:0][IW-1:0]      m_lo;
    logic [2:0][IW-1:0]      m_hi;
    logic [2:0][IW-1:0]      a_lo;
    logic [2:0][IW-1:0]      a_hi;

    logic                    valid_reg;
    logic [2:0][IW-1:0]      main_lo_reg;
    logic [2:0][IW-1:0]      main_hi_reg;
    logic [2:0][IW-1:0]      alt_lo_reg;
    logic [2:0][IW-1:0]      alt_hi_reg;
    hrb_flags_t              flags_reg;

    // clamp oversized registers to the configured limits
    assign cells_in = {cells_x3, cells_x2, cells_x1};
    assign ghost    = (GCW'(ghost_width) > GCW'(MAX_GHOST)) ? GW'(MAX_GHOST) : GW'(ghost_width);

    for (genvar i = 0; i < 3; i++)
    begin : g_clamp
        assign cells[i] = (CCW'(cells_in[i]) > CCW'(MAX_CELLS)) ? CW'(MAX_CELLS)
                                                                 : CW'(cells_in[i]);
    end

    // sub-block selector and split permission per axis
    assign dir         = {dir_x3, dir_x2, dir_x1};
    assign sel[0]      = sub_a;
    assign sel[1]      = (dir_x1 != 2'b00) ? sub_a : sub_b;
    assign sel[2]      = (dir_x1 != 2'b00 && dir_x2 != 2'b00) ? sub_a : sub_b;
    assign split_ok[0] = 1'b1;
    assign split_ok[1] = (cells[1] > CW'(1));
    assign split_ok[2] = (cells[2] > CW'(1));

    // classification of the request
    assign same_kind = (func == FN_SEND_SAME) || (func == FN_SEND_SAMEC) ||
                       (func == FN_RECV_SAME) || (func == FN_RECV_SAMEC);
    assign flags_next.valid_res = (func <= FN_RECV_FLUX) && !(same_kind && (sub_a || sub_b));
    assign flags_next.add_same  = (func == FN_SEND_SAMEC) || (func == FN_RECV_SAMEC);
    assign alt_func = (func == FN_SEND_SAMEC) ? FN_SEND_SAME : FN_RECV_SAME;

    // main box and the same-level box used by the coarse count
    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        hrb_axis #(
            .CW (CW),
            .GW (GW),
            .IW (IW)
        ) u_main (
            .func     (func),
            .dir      (dir[i]),
            .sel      (sel[i]),
            .split_ok (split_ok[i]),
            .ghost    (ghost),
            .cells    (cells[i]),
            .lo       (m_lo[i]),
            .hi       (m_hi[i])
        );

        hrb_axis #(
            .CW (CW),
            .GW (GW),
            .IW (IW)
        ) u_alt (
            .func     (alt_func),
            .dir      (dir[i]),
            .sel      (sel[i]),
            .split_ok (split_ok[i]),
            .ghost    (ghost),
            .cells    (cells[i]),
            .lo       (a_lo[i]),
            .hi       (a_hi[i])
        );
    end

    // output stage towards the queue
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            main_lo_reg <= m_lo;
            main_hi_reg <= m_hi;
            alt_lo_reg  <= a_lo;
            alt_hi_reg  <= a_hi;
            flags_reg   <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign main_lo   = main_lo_reg;
    assign main_hi   = main_hi_reg;
    assign alt_lo    = alt_lo_reg;
    assign alt_hi    = alt_hi_reg;
    assign flags     = flags_reg;

endmodule

`default_nettype wire

[rtl/hrb_fifo.sv]
// short queue between front and back ends
`default_nettype none

module hrb_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);
    import hrb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [NW-1:0] fill_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_next;
    logic [NW-1:0] fill_next;
    logic          push;
    logic          pop;

    assign in_ready  = (fill_reg != NW'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

[rtl/hrb_back.sv]
// back end: extents, cell count pipeline and the output register
`default_nettype none

module hrb_back #(
    parameter int IW = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0][IW-1:0]              main_lo,
    input  logic [2:0][IW-1:0]              main_hi,
    input  logic [2:0][IW-1:0]              alt_lo,
    input  logic [2:0][IW-1:0]              alt_hi,
    input  hrb_pkg::hrb_flags_t             flags,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hrb_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [hrb_pkg::M_USER_W-1:0]    m_tuser
);
    import hrb_pkg::*;

    localparam int EW = IW - 1;
    localparam int PW = 3 * EW;
    localparam int SW = PW + 1;
    localparam int BW = 6 * COORD_W;

    logic [2:0][EW-1:0]  ext_main;
    logic [2:0][EW-1:0]  ext_alt;
    logic [BW-1:0]       bounds;
    logic                adv1;
    logic                adv2;
    logic                adv3;

    logic                s1_valid_reg;
    logic [2*EW-1:0]     s1_pm_reg;
    logic [2*EW-1:0]     s1_pa_reg;
    logic [EW-1:0]       s1_em_reg;
    logic [EW-1:0]       s1_ea_reg;
    logic [BW-1:0]       s1_bounds_reg;
    hrb_flags_t          s1_flags_reg;

    logic                s2_valid_reg;
    logic [PW-1:0]       s2_pm_reg;
    logic [PW-1:0]       s2_pa_reg;
    logic [BW-1:0]       s2_bounds_reg;
    hrb_flags_t          s2_flags_reg;

    logic [SW-1:0]       sum;
    logic [COUNT_W-1:0]  count_sat;
    logic [M_DATA_W-1:0] data_next;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_user_reg;

    // extent of one axis, an empty range gives zero
    function automatic logic [EW-1:0] extent(input logic [IW-1:0] lo, input logic [IW-1:0] hi);
        logic [IW:0] d;
        d = {hi[IW-1], hi} - {lo[IW-1], lo} + (IW+1)'(1);
        return d[IW] ? '0 : d[EW-1:0];
    endfunction

    for (genvar i = 0; i < 3; i++)
    begin : g_ext
        assign ext_main[i] = extent(main_lo[i], main_hi[i]);
        assign ext_alt[i]  = extent(alt_lo[i], alt_hi[i]);
    end

    // result coordinates, lowest field first
    assign bounds = {main_hi[2][COORD_W-1:0], main_lo[2][COORD_W-1:0],
                     main_hi[1][COORD_W-1:0], main_lo[1][COORD_W-1:0],
                     main_hi[0][COORD_W-1:0], main_lo[0][COORD_W-1:0]};

    // stall chain, each stage moves when the one after it has room
    assign adv3     = !out_valid_reg || m_tready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage one: first two axes multiplied
    always_ff @(posedge clk)
    begin
        if (in_valid && adv1)
        begin
            s1_pm_reg     <= ext_main[0] * ext_main[1];
            s1_pa_reg     <= ext_alt[0] * ext_alt[1];
            s1_em_reg     <= ext_main[2];
            s1_ea_reg     <= ext_alt[2];
            s1_bounds_reg <= bounds;
            s1_flags_reg  <= flags;
        end
    end

    // stage two: third axis multiplied
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && adv2)
        begin
            s2_pm_reg     <= s1_pm_reg * s1_em_reg;
            s2_pa_reg     <= s1_pa_reg * s1_ea_reg;
            s2_bounds_reg <= s1_bounds_reg;
            s2_flags_reg  <= s1_flags_reg;
        end
    end

    // stage three: same-level count added, saturated, rejected items cleared
    assign sum       = SW'(s2_pm_reg) + (s2_flags_reg.add_same ? SW'(s2_pa_reg) : '0);
    assign count_sat = (sum > SW'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
    assign data_next = s2_flags_reg.valid_res
                     ? M_DATA_W'({count_sat, s2_bounds_reg}) : '0;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && adv3)
        begin
            out_data_reg <= data_next;
            out_user_reg <= s2_flags_reg.valid_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

[rtl/halo_region_bounds.sv]
// top level of the halo region bounds block
//
// For each request (region kind, neighbour direction, sub-block selectors) the
// block returns the cell index box of one neighbour buffer and its cell count.
// Channels: requests on s_tvalid/s_tready/s_tdata/s_tuser, results on
// m_tvalid/m_tready/m_tdata/m_tuser, register writes on cfg_valid/cfg_ready
// with cfg_index and cfg_data. cfg_ready is always high; write only when idle.
// Throughput: one request per cycle sustained, with no stall from the receiver.
// Path from a request transfer to its result on m_tvalid: one front stage that
// decodes and builds both boxes, the queue, and the two-multiplier count
// pipeline whose last stage is the output register.
// A four-entry queue sits between the front and the count pipeline; when the
// receiver holds m_tready low the pipeline stops, the queue fills and then
// s_tready drops. No result is lost or repeated.
// Reset clears all valid state and loads ghost_width 2 and 16 cells per axis.
`default_nettype none

module halo_region_bounds #(
    parameter int MAX_CELLS = hrb_pkg::DEF_MAX_CELLS,
    parameter int MAX_GHOST = hrb_pkg::DEF_MAX_GHOST
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // dir_x1[1:0], dir_x2[3:2], dir_x3[5:4], sub_a[6], sub_b[7]
    input  logic [hrb_pkg::S_DATA_W-1:0]    s_tdata,
    // func[3:0]
    input  logic [hrb_pkg::S_USER_W-1:0]    s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // start_x1[10:0], stop_x1[21:11], start_x2[32:22], stop_x2[43:33],
    // start_x3[54:44], stop_x3[65:55], cell_count[90:66], zero fill[95:91]
    output logic [hrb_pkg::M_DATA_W-1:0]    m_tdata,
    // valid_res[0]
    output logic [hrb_pkg::M_USER_W-1:0]    m_tuser,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  hrb_pkg::reg_idx_t               cfg_index,
    input  logic [hrb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hrb_pkg::*;

    localparam int IW_RAW = $clog2(2 * MAX_CELLS + 2 * MAX_GHOST) + 2;
    localparam int IW     = (IW_RAW > COORD_W) ? IW_RAW : COORD_W;
    localparam int QW     = 12 * IW + $bits(hrb_flags_t);

    logic [GHOST_W-1:0]  ghost_width_reg;
    logic [CELLS_W-1:0]  cells_x1_reg;
    logic [CELLS_W-1:0]  cells_x2_reg;
    logic [CELLS_W-1:0]  cells_x3_reg;

    logic                front_valid;
    logic                front_ready;
    logic [2:0][IW-1:0]  front_main_lo;
    logic [2:0][IW-1:0]  front_main_hi;
    logic [2:0][IW-1:0]  front_alt_lo;
    logic [2:0][IW-1:0]  front_alt_hi;
    hrb_flags_t          front_flags;
    logic [QW-1:0]       queue_in;

    logic                queue_valid;
    logic                queue_ready;
    logic [QW-1:0]       queue_out;
    logic [2:0][IW-1:0]  back_main_lo;
    logic [2:0][IW-1:0]  back_main_hi;
    logic [2:0][IW-1:0]  back_alt_lo;
    logic [2:0][IW-1:0]  back_alt_hi;
    hrb_flags_t          back_flags;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ghost_width_reg <= GHOST_RESET;
            cells_x1_reg    <= CELLS_RESET;
            cells_x2_reg    <= CELLS_RESET;
            cells_x3_reg    <= CELLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GHOST_WIDTH: ghost_width_reg <= cfg_data[GHOST_W-1:0];
                REG_CELLS_X1:    cells_x1_reg    <= cfg_data[CELLS_W-1:0];
                REG_CELLS_X2:    cells_x2_reg    <= cfg_data[CELLS_W-1:0];
                REG_CELLS_X3:    cells_x3_reg    <= cfg_data[CELLS_W-1:0];
                default:         ghost_width_reg <= ghost_width_reg;
            endcase
        end
    end

    // front end
    hrb_front #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_GHOST (MAX_GHOST),
        .IW        (IW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .func        (s_tuser[3:0]),
        .dir_x1      (s_tdata[1:0]),
        .dir_x2      (s_tdata[3:2]),
        .dir_x3      (s_tdata[5:4]),
        .sub_a       (s_tdata[6]),
        .sub_b       (s_tdata[7]),
        .ghost_width (ghost_width_reg),
        .cells_x1    (cells_x1_reg),
        .cells_x2    (cells_x2_reg),
        .cells_x3    (cells_x3_reg),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .main_lo     (front_main_lo),
        .main_hi     (front_main_hi),
        .alt_lo      (front_alt_lo),
        .alt_hi      (front_alt_hi),
        .flags       (front_flags)
    );

    // queue between the two ends
    assign queue_in = {front_flags, front_alt_hi, front_alt_lo, front_main_hi, front_main_lo};

    hrb_fifo #(
        .DW    (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (queue_in),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_data  (queue_out)
    );

    assign {back_flags, back_alt_hi, back_alt_lo, back_main_hi, back_main_lo} = queue_out;

    // back end
    hrb_back #(
        .IW (IW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (queue_valid),
        .in_ready (queue_ready),
        .main_lo  (back_main_lo),
        .main_hi  (back_main_hi),
        .alt_lo   (back_alt_lo),
        .alt_hi   (back_alt_hi),
        .flags    (back_flags),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a rejected request leaves no box and no count behind
    a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("rejected result carries nonzero fields");

    // the front holds its item while the queue is full
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !front_ready |=> front_valid && $stable(queue_in))
        else $error("front item changed while the queue was full");

    // the queue takes nothing that the front has not offered
    a_queue_source: assert property (@(posedge clk) disable iff (!rst_n)
        !front_valid && !queue_valid |=> !queue_valid)
        else $error("queue produced an item from nowhere");

endmodule

`default_nettype wire

[verif/halo_region_bounds_tb.sv]
// testbench for halo_region_bounds: directed and random box requests checked by a scoreboard
module halo_region_bounds_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrb_pkg::*;

    localparam int MAX_C = DEF_MAX_CELLS;
    localparam int MAX_G = DEF_MAX_GHOST;

    // expected box of one request
    typedef struct packed {
        logic [2:0][COORD_W-1:0] lo;
        logic [2:0][COORD_W-1:0] hi;
        logic [COUNT_W-1:0]      count;
        logic                    ok;
    } box_t;

    class box_scoreboard;
        logic [GHOST_W-1:0] ghost;
        logic [CELLS_W-1:0] cells [3];
        box_t pending_boxes [$];
        int errors;

        function new();
            ghost = GHOST_RESET;
            foreach (cells[i])
                cells[i] = CELLS_RESET;
            errors = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_GHOST_WIDTH: ghost    = val[GHOST_W-1:0];
                REG_CELLS_X1:    cells[0] = val;
                REG_CELLS_X2:    cells[1] = val;
                REG_CELLS_X3:    cells[2] = val;
                default: ;
            endcase
        endfunction

        // first and last cell on one axis
        function void axis_span(func_t f, int ox, bit sel, bit splitok, int g, int n,
                                output int lo, output int hi);
            bit col;
            bit split;
            int s, e, ce, cn, w, a, b;
            col = (n <= 1);
            s = col ? 0 : g;
            e = col ? 0 : g + n - 1;
            ce = col ? 0 : g + n / 2 - 1;
            cn = n / 2;
            w = (f == FN_RECV_PROLONG) ? g / 2 : g;
            split = (ox == 0) && splitok;
            a = s;
            case (f)
                FN_SEND_SAMEC, FN_SEND_COARSER, FN_SEND_FLUX, FN_RECV_SAMEC,
                FN_RECV_COARSER, FN_RECV_PROLONG: b = ce;
                default: b = e;
            endcase

            if (f <= FN_SEND_FINER) begin
                // send kinds: a ghost-wide slab next to the neighbour
                lo = (ox > 0) ? b - (g - 1) : a;
                hi = (ox < 0) ? a + (g - 1) : b;
                if (f == FN_SEND_FINER && split) begin
                    if (sel)
                        lo += cn - g;
                    else
                        hi -= cn - g;
                end
            end
            else if (f == FN_SEND_FLUX || f == FN_RECV_FLUX) begin
                // flux faces are a single layer
                if (ox == 0) begin
                    lo = a;
                    hi = b;
                end
                else if (ox > 0) begin
                    lo = b + 1;
                    hi = b + 1;
                end
                else begin
                    lo = a;
                    hi = a;
                end
                if (f == FN_RECV_FLUX && split) begin
                    if (sel)
                        lo += cn;
                    else
                        hi -= cn;
                end
            end
            else begin
                // receive kinds land in the ghost zone
                if (ox == 0) begin
                    lo = a;
                    hi = b;
                end
                else if (ox > 0) begin
                    lo = b + 1;
                    hi = b + w;
                end
                else begin
                    lo = a - w;
                    hi = a - 1;
                end
                if (split && (f == FN_RECV_COARSER || f == FN_RECV_PROLONG)) begin
                    if (sel == 1'b0)
                        hi += w;
                    else
                        lo -= w;
                end
                if (split && f == FN_RECV_FINER) begin
                    if (sel)
                        lo += cn;
                    else
                        hi -= cn;
                end
            end
        endfunction

        function void span_3d(func_t f, int ox [3], bit sa, bit sb, int g, int n [3],
                              output int lo [3], output int hi [3]);
            bit sel2, sel3;
            sel2 = (ox[0] != 0) ? sa : sb;
            sel3 = (ox[0] != 0 && ox[1] != 0) ? sa : sb;
            axis_span(f, ox[0], sa, 1'b1, g, n[0], lo[0], hi[0]);
            axis_span(f, ox[1], sel2, n[1] > 1, g, n[1], lo[1], hi[1]);
            axis_span(f, ox[2], sel3, n[2] > 1, g, n[2], lo[2], hi[2]);
        endfunction

        // empty extents count as zero cells
        function longint box_cells(int lo [3], int hi [3]);
            longint c;
            longint ext;
            c = 1;
            for (int i = 0; i < 3; i++) begin
                ext = hi[i] - lo[i] + 1;
                if (ext < 0)
                    ext = 0;
                c *= ext;
            end
            return c;
        endfunction

        function box_t region_box(func_t f, logic [S_DATA_W-1:0] d);
            box_t r;
            int g;
            int ox [3];
            int n [3];
            int lo [3], hi [3], lo2 [3], hi2 [3];
            bit sa, sb, same;
            longint cnt;
            r = '0;
            sa = d[6];
            sb = d[7];
            same = (f == FN_SEND_SAME || f == FN_SEND_SAMEC ||
                    f == FN_RECV_SAME || f == FN_RECV_SAMEC);
            // unknown kinds and same-level kinds with a sub-block give an empty result
            if (f > FN_RECV_FLUX || (same && (sa || sb)))
                return r;
            g = (ghost > MAX_G) ? MAX_G : int'(ghost);
            for (int i = 0; i < 3; i++) begin
                ox[i] = int'($signed(d[2*i +: 2]));
                n[i] = (cells[i] > MAX_C) ? MAX_C : int'(cells[i]);
            end
            span_3d(f, ox, sa, sb, g, n, lo, hi);
            cnt = box_cells(lo, hi);
            // same-level coarse also carries the same-level box
            if (f == FN_SEND_SAMEC || f == FN_RECV_SAMEC) begin
                span_3d((f == FN_SEND_SAMEC) ? FN_SEND_SAME : FN_RECV_SAME,
                        ox, sa, sb, g, n, lo2, hi2);
                cnt += box_cells(lo2, hi2);
            end
            if (cnt > COUNT_MAX)
                cnt = COUNT_MAX;
            for (int i = 0; i < 3; i++) begin
                r.lo[i] = COORD_W'(lo[i]);
                r.hi[i] = COORD_W'(hi[i]);
            end
            r.count = COUNT_W'(cnt);
            r.ok = 1'b1;
            return r;
        endfunction

        function void note_request(func_t f, logic [S_DATA_W-1:0] d);
            pending_boxes.push_back(region_box(f, d));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user);
            box_t want;
            if (pending_boxes.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, got data %h user %b",
                         $time, data, user);
                return;
            end
            want = pending_boxes.pop_front();
            for (int i = 0; i < 3; i++) begin
                compare_field($sformatf("start_x%0d", i + 1), int'($signed(want.lo[i])),
                              int'($signed(data[22*i +: COORD_W])));
                compare_field($sformatf("stop_x%0d", i + 1), int'($signed(want.hi[i])),
                              int'($signed(data[22*i+11 +: COORD_W])));
            end
            compare_field("cell_count", int'(want.count), int'(data[90:66]));
            compare_field("valid_res", int'(want.ok), int'(user[0]));
        endfunction

        function int pending();
            return pending_boxes.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    reg_idx_t              cfg_index = REG_GHOST_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    box_scoreboard board = new();
    bit idle_on = 1'b1;
    int stall_left = 0;

    halo_region_bounds dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // result side: check each transfer, stall at random while idle_on is set
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!idle_on || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end
        else begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end
    end

    // one request transfer; valid stays high for a back-to-back follower
    task automatic send_request(input func_t f, input logic [S_DATA_W-1:0] d);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(f, d);
    endtask

    // write all four registers; spare ghost bits get random filler
    task automatic configure(input logic [GHOST_W-1:0] g, input logic [CELLS_W-1:0] c1,
                             input logic [CELLS_W-1:0] c2, input logic [CELLS_W-1:0] c3);
        reg_idx_t idxs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idxs = '{REG_GHOST_WIDTH, REG_CELLS_X1, REG_CELLS_X2, REG_CELLS_X3};
        vals[0] = {5'($urandom_range(0, 31)), g};
        vals[1] = c1;
        vals[2] = c2;
        vals[3] = c3;
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            board.write_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // random request, mostly well-formed
    task automatic send_random();
        func_t f;
        logic [S_DATA_W-1:0] d;
        if ($urandom_range(0, 99) < 85) begin
            f = func_t'($urandom_range(0, 10));
            for (int i = 0; i < 3; i++)
                case ($urandom_range(0, 2))
                    0: d[2*i +: 2] = 2'b11;
                    1: d[2*i +: 2] = 2'b00;
                    default: d[2*i +: 2] = 2'b01;
                endcase
            d[7:6] = 2'($urandom_range(0, 3));
            if ((f == FN_SEND_SAME || f == FN_SEND_SAMEC || f == FN_RECV_SAME ||
                 f == FN_RECV_SAMEC) && $urandom_range(0, 3) != 0)
                d[7:6] = 2'b00;
        end
        else begin
            f = func_t'($urandom_range(0, 15));
            d = S_DATA_W'($urandom_range(0, 255));
        end
        send_request(f, d);
    endtask

    initial begin : stimulus
        logic [GHOST_W-1:0] ghost_set [10];
        logic [CELLS_W-1:0] c1_set [10];
        logic [CELLS_W-1:0] c2_set [10];
        logic [CELLS_W-1:0] c3_set [10];

        // reset settings first, then minimum, maximum, oversized, odd and collapsed cases
        ghost_set = '{4'd2, 4'd1, 4'd8, 4'd15, 4'd3, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0};
        c1_set = '{9'd16, 9'd2, 9'd256, 9'd511, 9'd15, 9'd1, 9'd0, 9'd0, 9'd0, 9'd0};
        c2_set = '{9'd16, 9'd1, 9'd256, 9'd300, 9'd7, 9'd1, 9'd2, 9'd0, 9'd0, 9'd0};
        c3_set = '{9'd16, 9'd1, 9'd256, 9'd257, 9'd1, 9'd9, 9'd256, 9'd0, 9'd0, 9'd0};
        for (int p = 7; p < 10; p++) begin
            ghost_set[p] = GHOST_W'($urandom_range(0, 15));
            c1_set[p] = ($urandom_range(0, 3) == 0) ? CELLS_W'($urandom_range(0, 511))
                                                    : CELLS_W'($urandom_range(1, 64));
            c2_set[p] = ($urandom_range(0, 3) == 0) ? CELLS_W'($urandom_range(0, 511))
                                                    : CELLS_W'($urandom_range(1, 64));
            c3_set[p] = ($urandom_range(0, 3) == 0) ? CELLS_W'($urandom_range(0, 511))
                                                    : CELLS_W'($urandom_range(1, 64));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every kind with no offset, then sub-blocks and odd offsets
        for (int f = 0; f < 16; f++)
            send_request(func_t'(f), 8'h00);
        send_request(FN_SEND_SAME, 8'b01_00_00_00);
        send_request(FN_RECV_SAMEC, 8'b10_00_00_00);
        send_request(FN_SEND_FINER, 8'b00_10_10_10);
        send_request(FN_SEND_FINER, 8'b01_00_00_01);
        send_request(FN_RECV_FINER, 8'b11_00_00_00);
        send_request(FN_RECV_FLUX, 8'b11_00_00_11);
        send_request(FN_RECV_COARSER, 8'b01_00_01_00);
        send_request(FN_RECV_PROLONG, 8'b01_00_01_01);
        send_request(FN_SEND_FLUX, 8'b00_11_11_11);

        for (int p = 0; p < 10; p++) begin
            idle_on = (p % 4 != 3);
            // registers only change once every result is back
            if (p > 0) begin
                while (board.pending() != 0)
                    @(posedge clk);
                configure(ghost_set[p], c1_set[p], c2_set[p], c3_set[p]);
            end
            repeat (153) send_random();
            s_tvalid <= 1'b0;
        end

        // drain, then let any stray result show up
        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/hrb_pkg.sv
rtl/hrb_axis.sv
rtl/hrb_front.sv
rtl/hrb_fifo.sv
rtl/hrb_back.sv
rtl/halo_region_bounds.sv
verif/halo_region_bounds_tb.sv
